[rtl/enms_pkg.sv]
// shared types, register indexes and helpers for the edge suppression block
`default_nettype none
package enms_pkg;

  localparam int unsigned MAG_W     = 8;
  localparam int unsigned DIR_IN_W  = 8;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned CFG_DIM_W = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIR_IN_W-1:0] DEG_0   = 8'd0;
  localparam logic [DIR_IN_W-1:0] DEG_45  = 8'd45;
  localparam logic [DIR_IN_W-1:0] DEG_90  = 8'd90;
  localparam logic [DIR_IN_W-1:0] DEG_135 = 8'd135;

  localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_LOW_LEVEL    = 3'd2,
    CFG_HIGH_LEVEL   = 3'd3,
    CFG_STRONG_CODE  = 3'd4,
    CFG_WEAK_CODE    = 3'd5,
    CFG_NONE_CODE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    DIR_H    = 3'd0,
    DIR_D45  = 3'd1,
    DIR_V    = 3'd2,
    DIR_D135 = 3'd3,
    DIR_NONE = 3'd4
  } dir_e;

  typedef struct packed {
    logic [MAG_W-1:0]    magnitude_in;
    logic [DIR_IN_W-1:0] direction_in;
  } pix_in_t;

  typedef struct packed {
    logic [POS_W-1:0]   center_x;
    logic [POS_W-1:0]   center_y;
    logic [MAG_W-1:0]   kept_magnitude;
    logic [CLASS_W-1:0] edge_class;
    logic [MAG_W-1:0]   edge_value;
    logic               frame_last;
  } pix_out_t;

  // one line store entry: both magnitude rows and the direction row
  typedef struct packed {
    logic [MAG_W-1:0] upper;
    logic [MAG_W-1:0] middle;
    dir_e             dir;
  } line_t;

  // new right-hand column entering the 3x3 window
  typedef struct packed {
    logic [MAG_W-1:0] upper;
    logic [MAG_W-1:0] middle;
    logic [MAG_W-1:0] lower;
    dir_e             dir;
  } win_col_t;

  function automatic dir_e dir_encode(input logic [DIR_IN_W-1:0] d);
    dir_e r;
    r = DIR_NONE;
    if (d == DEG_0) begin
      r = DIR_H;
    end else if (d == DEG_45) begin
      r = DIR_D45;
    end else if (d == DEG_90) begin
      r = DIR_V;
    end else if (d == DEG_135) begin
      r = DIR_D135;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/edge_nms_double_threshold_unit.sv]
// top level: line store, pixel counters, suppression pipeline and output register
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (magnitude, direction)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (position, class, code)
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// one pixel per clock sustained while the output is not stalled
// the line store is one ram read at pixel entry, written back as the pixel leaves stage 1
// border pixels give no result; line store contents are unknown after reset
// stalls back up stage by stage, so gaps collapse while the output register waits
`default_nettype none
module edge_nms_double_threshold_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire enms_pkg::pix_in_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output enms_pkg::pix_out_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [enms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [enms_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import enms_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CWX = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
  localparam int unsigned CWY = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;

  // configuration
  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [MAG_W-1:0]     low_q, high_q, strong_q, weak_q, none_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      low_q    <= 8'd20;
      high_q   <= 8'd60;
      strong_q <= 8'd255;
      weak_q   <= 8'd128;
      none_q   <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[CFG_DIM_W-1:0];
        CFG_LOW_LEVEL:    low_q    <= cfg_wdata_i[MAG_W-1:0];
        CFG_HIGH_LEVEL:   high_q   <= cfg_wdata_i[MAG_W-1:0];
        CFG_STRONG_CODE:  strong_q <= cfg_wdata_i[MAG_W-1:0];
        CFG_WEAK_CODE:    weak_q   <= cfg_wdata_i[MAG_W-1:0];
        CFG_NONE_CODE:    none_q   <= cfg_wdata_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  logic [CWX-1:0] width_ext;
  logic [CWY-1:0] height_ext;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;

  always_comb begin
    width_ext  = CWX'(width_q);
    height_ext = CWY'(height_q);
    if (width_ext < CWX'(3)) begin
      w_eff = WW'(3);
    end else if (width_ext > CWX'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_ext);
    end
    if (height_ext < CWY'(3)) begin
      h_eff = HW'(3);
    end else if (height_ext > CWY'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_ext);
    end
  end

  // pipeline handshake
  logic accept, en1, en2, en_out, s1_adv, out_load;
  logic v1_q, v2_q, out_valid_q;

  // stage 1: line store read in flight
  logic [XW-1:0]    x1_q, x2_q;
  logic [YW-1:0]    y1_q, y2_q;
  logic [MAG_W-1:0] mag1_q;
  dir_e             dir1_q;
  logic             emit1_q, last1_q, emit2_q, last2_q;

  assign en_out   = !out_valid_q || !out_stall_i;
  assign en2      = !v2_q || !emit2_q || en_out;
  assign en1      = !v1_q || en2;
  assign accept   = in_valid_i && en1;
  assign s1_adv   = v1_q && en2;
  assign out_load = v2_q && emit2_q && en_out;
  assign in_stall_o = !en1;

  // raster position of the incoming pixel
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [HW-1:0] row_t;
  logic [WW-1:0] x0_inc;
  logic [HW-1:0] y0_inc;
  logic          emit0, last0;

  always_comb begin
    if (WW'(col_q) >= w_eff) begin
      x0    = '0;
      row_t = HW'(row_q) + HW'(1);
    end else begin
      x0    = col_q;
      row_t = HW'(row_q);
    end
    y0     = (row_t >= h_eff) ? '0 : row_t[YW-1:0];
    x0_inc = WW'(x0) + WW'(1);
    y0_inc = HW'(y0) + HW'(1);
    emit0  = (x0 >= XW'(2)) && (y0 >= YW'(2));
    last0  = (x0_inc == w_eff) && (y0_inc == h_eff);
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (x0_inc >= w_eff) begin
        col_d = '0;
        row_d = (y0_inc >= h_eff) ? '0 : y0_inc[YW-1:0];
      end else begin
        col_d = x0_inc[XW-1:0];
        row_d = y0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store: read at entry, written back as the pixel leaves stage 1
  line_t ram_rd, ram_wd;
  logic  [$bits(line_t)-1:0] ram_rdata;

  assign ram_rd = line_t'(ram_rdata);
  always_comb begin
    ram_wd.upper  = ram_rd.middle;
    ram_wd.middle = mag1_q;
    ram_wd.dir    = dir1_q;
  end

  enms_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (x1_q),
    .wdata_i (ram_wd),
    .re_i    (accept),
    .raddr_i (x0),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= x0;
      y1_q    <= y0;
      mag1_q  <= in_data_i.magnitude_in;
      dir1_q  <= dir_encode(in_data_i.direction_in);
      emit1_q <= emit0;
      last1_q <= last0;
    end
  end

  // stage 2: window centre is one column left and one row above this pixel
  win_col_t         win_col;
  logic [MAG_W-1:0] kept;

  always_comb begin
    win_col.upper  = ram_rd.upper;
    win_col.middle = ram_rd.middle;
    win_col.lower  = mag1_q;
    win_col.dir    = ram_rd.dir;
  end

  enms_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (win_col),
    .kept_o  (kept)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      emit2_q <= 1'b0;
    end else if (en2) begin
      v2_q    <= v1_q;
      emit2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      last2_q <= last1_q;
    end
  end

  // double threshold and output register
  pix_out_t      res, out_q;
  logic [XW-1:0] xm1;
  logic [YW-1:0] ym1;

  always_comb begin
    xm1                = x2_q - XW'(1);
    ym1                = y2_q - YW'(1);
    res.center_x       = POS_W'(xm1);
    res.center_y       = POS_W'(ym1);
    res.kept_magnitude = kept;
    res.frame_last     = last2_q;
    if (kept >= high_q) begin
      res.edge_class = CLASS_STRONG;
      res.edge_value = strong_q;
    end else if (kept >= low_q) begin
      res.edge_class = CLASS_WEAK;
      res.edge_value = weak_q;
    end else begin
      res.edge_class = CLASS_NONE;
      res.edge_value = none_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a pixel never reads the entry that the one ahead of it is writing back
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_adv) |-> (x0 != x1_q))
    else $error("line store read and write hit the same column");

  // a pixel held in stage 1 stays there until it moves on
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en2) |=> v1_q)
    else $error("stage 1 pixel lost while stalled");

  // the frame end marker only travels with an emitting pixel
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last2_q) |-> (x2_q >= XW'(2) && y2_q >= YW'(2)))
    else $error("frame end on a border pixel");

  // an accepted pixel always lands in stage 1
  a_entry_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted pixel missing from stage 1");

endmodule
`default_nettype wire

[rtl/enms_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none
module enms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/enms_window.sv]
// 3x3 magnitude window, centre direction delay and the suppression compare
`default_nettype none
module enms_window (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    shift_i,
  input  wire enms_pkg::win_col_t      col_i,
  output logic [enms_pkg::MAG_W-1:0]   kept_o
);
  import enms_pkg::*;

  // row-major: top, middle, bottom; left to right
  logic [MAG_W-1:0] win_q [9];
  logic [MAG_W-1:0] win_d [9];
  dir_e             cdir_q [2];
  dir_e             cdir_d [2];
  logic [MAG_W-1:0] nb1, nb2, centre;

  always_comb begin
    win_d  = win_q;
    cdir_d = cdir_q;
    if (shift_i) begin
      win_d[0]  = win_q[1];
      win_d[1]  = win_q[2];
      win_d[2]  = col_i.upper;
      win_d[3]  = win_q[4];
      win_d[4]  = win_q[5];
      win_d[5]  = col_i.middle;
      win_d[6]  = win_q[7];
      win_d[7]  = win_q[8];
      win_d[8]  = col_i.lower;
      cdir_d[1] = cdir_q[0];
      cdir_d[0] = col_i.dir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      cdir_q[0] <= DIR_H;
      cdir_q[1] <= DIR_H;
    end else begin
      win_q  <= win_d;
      cdir_q <= cdir_d;
    end
  end

  // neighbours along the gradient of the centre pixel
  always_comb begin
    centre = win_q[4];
    case (cdir_q[1])
      DIR_H: begin
        nb1 = win_q[3];
        nb2 = win_q[5];
      end
      DIR_D45: begin
        nb1 = win_q[2];
        nb2 = win_q[6];
      end
      DIR_V: begin
        nb1 = win_q[1];
        nb2 = win_q[7];
      end
      DIR_D135: begin
        nb1 = win_q[0];
        nb2 = win_q[8];
      end
      default: begin
        nb1 = '0;
        nb2 = '0;
      end
    endcase
    kept_o = (centre >= nb1 && centre >= nb2) ? centre : '0;
  end

endmodule
`default_nettype wire
